### sv/csg_pkg.sv
// Package for the circle span generator: field widths, register indexes,
// span phase codes and the structs shared by the block's modules.
// Depends on nothing; every other file of the block uses it.
package csg_pkg;

    // Field widths
    localparam int CLIP_BITS   = 12;
    localparam int CENTRE_BITS = 12;
    localparam int DIAM_BITS   = 11;
    localparam int STEP_BITS   = 11;
    localparam int RADIUS_BITS = 10;
    localparam int DEC_BITS    = 16;
    localparam int PHASE_BITS  = 3;
    localparam int INDEX_BITS  = 2;

    // Coordinate defaults and the width spans are formed in before truncation
    localparam int COORD_BITS_DEF = 13;
    localparam int SUM_BITS       = 17;

    // Clip register indexes
    localparam logic [INDEX_BITS-1:0] REG_CLIP_LEFT   = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_CLIP_RIGHT  = 2'd1;
    localparam logic [INDEX_BITS-1:0] REG_CLIP_TOP    = 2'd2;
    localparam logic [INDEX_BITS-1:0] REG_CLIP_BOTTOM = 2'd3;

    // Clip register reset values
    localparam logic [CLIP_BITS-1:0] CLIP_LOW_RESET  = 12'd0;
    localparam logic [CLIP_BITS-1:0] CLIP_HIGH_RESET = 12'd4095;

    // Commands
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // Span phases: which span of the current step goes out next
    localparam logic [PHASE_BITS-1:0] PH_ABOVE_X = 3'd0; // row centre-x, half width y
    localparam logic [PHASE_BITS-1:0] PH_BELOW_X = 3'd1; // row centre+x, half width y
    localparam logic [PHASE_BITS-1:0] PH_ABOVE_Y = 3'd2; // row centre-y, half width x
    localparam logic [PHASE_BITS-1:0] PH_BELOW_Y = 3'd3; // row centre+y, half width x
    localparam logic [PHASE_BITS-1:0] PH_CLOSE   = 3'd5; // closing row centre+y
    localparam logic [PHASE_BITS-1:0] PH_END     = 3'd6; // closing pair sent

    // Decision increments
    localparam logic signed [DEC_BITS-1:0] DEC_INIT     = 16'sd3;
    localparam logic signed [DEC_BITS-1:0] DEC_STEP_X   = 16'sd6;
    localparam logic signed [DEC_BITS-1:0] DEC_STEP_XY  = 16'sd10;

    typedef struct packed {
        logic [CLIP_BITS-1:0] left;
        logic [CLIP_BITS-1:0] right;
        logic [CLIP_BITS-1:0] top;
        logic [CLIP_BITS-1:0] bottom;
    } clip_t;

    typedef struct packed {
        logic                          command;
        logic signed [CENTRE_BITS-1:0] centre_x;
        logic signed [CENTRE_BITS-1:0] centre_y;
        logic [DIAM_BITS-1:0]          diameter;
    } item_t;

    typedef struct packed {
        logic span_valid;
        logic last_span;
        logic done_res;
    } flags_t;

endpackage

### sv/csg_cfg_regs.sv
// Clip rectangle registers of the circle span generator, written through
// the configuration channel. Depends on csg_pkg.
module csg_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [csg_pkg::INDEX_BITS-1:0]   cfg_index,
    input  logic [csg_pkg::CLIP_BITS-1:0]    cfg_data,
    output csg_pkg::clip_t                   clip
);

    csg_pkg::clip_t clip_reg;
    csg_pkg::clip_t clip_next;
    logic           wr_en;

    // Take a write in every cycle
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    // Decode the register index
    always_comb
    begin
        clip_next = clip_reg;
        if (wr_en)
        begin
            case (cfg_index)
                csg_pkg::REG_CLIP_LEFT:   clip_next.left   = cfg_data;
                csg_pkg::REG_CLIP_RIGHT:  clip_next.right  = cfg_data;
                csg_pkg::REG_CLIP_TOP:    clip_next.top    = cfg_data;
                csg_pkg::REG_CLIP_BOTTOM: clip_next.bottom = cfg_data;
                default:                  clip_next        = clip_reg;
            endcase
        end
    end

    // Hold the clip rectangle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg.left   <= csg_pkg::CLIP_LOW_RESET;
            clip_reg.right  <= csg_pkg::CLIP_HIGH_RESET;
            clip_reg.top    <= csg_pkg::CLIP_LOW_RESET;
            clip_reg.bottom <= csg_pkg::CLIP_HIGH_RESET;
        end
        else
        begin
            clip_reg <= clip_next;
        end
    end

    assign clip = clip_reg;

endmodule

### sv/csg_step.sv
// Circle state and the one-pass span logic: start, reject, and the next
// span in midpoint order with its last mark. Depends on csg_pkg.
module csg_step
#(
    parameter int COORD_BITS = csg_pkg::COORD_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  csg_pkg::item_t                item,
    input  csg_pkg::clip_t                clip,
    output csg_pkg::flags_t               flags,
    output logic signed [COORD_BITS-1:0]  left,
    output logic signed [COORD_BITS-1:0]  right,
    output logic signed [COORD_BITS-1:0]  row
);

    localparam int CB = csg_pkg::CENTRE_BITS;
    localparam int SB = csg_pkg::STEP_BITS;
    localparam int DB = csg_pkg::DEC_BITS;
    localparam int WB = csg_pkg::SUM_BITS;
    localparam int RB = csg_pkg::RADIUS_BITS;

    logic signed [CB-1:0]               centre_col_reg, centre_col_next;
    logic signed [CB-1:0]               centre_row_reg, centre_row_next;
    logic [SB-1:0]                      step_x_reg, step_x_next;
    logic [SB-1:0]                      step_y_reg, step_y_next;
    logic signed [DB-1:0]               decision_reg, decision_next;
    logic [csg_pkg::PHASE_BITS-1:0]     phase_reg, phase_next;
    logic                               active_reg, active_next;

    logic [RB-1:0]                      radius;
    logic signed [13:0]                 r_w, cx_w, cy_w;
    logic signed [13:0]                 cl_w, cr_w, ct_w, cb_w;
    logic                               reject;
    logic signed [11:0]                 x_minus_y;
    logic [SB-1:0]                      half;
    logic [SB-1:0]                      offset;
    logic                               below;
    logic signed [WB-1:0]               col_w, row_w, half_w, off_w;
    logic signed [WB-1:0]               left_w, right_w, row_out_w;
    logic                               keep_going;

    // Bounding-box reject against the clip rectangle
    always_comb
    begin
        radius = item.diameter[csg_pkg::DIAM_BITS-1:1];
        r_w    = $signed({4'b0, radius});
        cx_w   = $signed({{2{item.centre_x[CB-1]}}, item.centre_x});
        cy_w   = $signed({{2{item.centre_y[CB-1]}}, item.centre_y});
        cl_w   = $signed({2'b0, clip.left});
        cr_w   = $signed({2'b0, clip.right});
        ct_w   = $signed({2'b0, clip.top});
        cb_w   = $signed({2'b0, clip.bottom});
        reject = (cx_w + r_w < cl_w) || (cx_w - r_w > cr_w) ||
                 (cy_w + r_w < ct_w) || (cy_w - r_w > cb_w);
    end

    // Next state and the span of this transfer
    always_comb
    begin
        centre_col_next = centre_col_reg;
        centre_row_next = centre_row_reg;
        step_x_next     = step_x_reg;
        step_y_next     = step_y_reg;
        decision_next   = decision_reg;
        phase_next      = phase_reg;
        active_next     = active_reg;
        flags           = '0;
        half            = '0;
        offset          = '0;
        below           = 1'b0;
        keep_going      = 1'b1;
        x_minus_y       = $signed({1'b0, step_x_reg}) - $signed({1'b0, step_y_reg});

        if (fire)
        begin
            if (item.command == csg_pkg::CMD_START)
            begin
                centre_col_next = item.centre_x;
                centre_row_next = item.centre_y;
                step_x_next     = '0;
                step_y_next     = {1'b0, radius};
                decision_next   = csg_pkg::DEC_INIT - $signed({5'b0, item.diameter});
                phase_next      = csg_pkg::PH_ABOVE_X;
                active_next     = !reject;
                flags.done_res  = reject;
            end
            else if (!active_reg)
            begin
                flags.done_res = 1'b1;
            end
            else
            begin
                flags.span_valid = 1'b1;
                case (phase_reg)
                    csg_pkg::PH_ABOVE_X:
                    begin
                        if (step_x_reg < step_y_reg)
                        begin
                            half       = step_y_reg;
                            offset     = step_x_reg;
                            phase_next = csg_pkg::PH_BELOW_X;
                        end
                        else
                        begin
                            half       = step_x_reg;
                            offset     = step_y_reg;
                            phase_next = csg_pkg::PH_CLOSE;
                        end
                    end
                    csg_pkg::PH_BELOW_X:
                    begin
                        half   = step_y_reg;
                        offset = step_x_reg;
                        below  = 1'b1;
                        if (decision_reg < 0)
                        begin
                            decision_next = decision_reg
                                + $signed({3'b0, step_x_reg, 2'b00}) + csg_pkg::DEC_STEP_X;
                            step_x_next   = step_x_reg + 1'b1;
                            phase_next    = csg_pkg::PH_ABOVE_X;
                        end
                        else
                        begin
                            phase_next = csg_pkg::PH_ABOVE_Y;
                        end
                    end
                    csg_pkg::PH_ABOVE_Y:
                    begin
                        half       = step_x_reg;
                        offset     = step_y_reg;
                        phase_next = csg_pkg::PH_BELOW_Y;
                    end
                    csg_pkg::PH_BELOW_Y:
                    begin
                        half          = step_x_reg;
                        offset        = step_y_reg;
                        below         = 1'b1;
                        decision_next = decision_reg
                            + $signed({{2{x_minus_y[11]}}, x_minus_y, 2'b00})
                            + csg_pkg::DEC_STEP_XY;
                        step_y_next   = step_y_reg - 1'b1;
                        step_x_next   = step_x_reg + 1'b1;
                        phase_next    = csg_pkg::PH_ABOVE_X;
                    end
                    default:
                    begin
                        half       = step_x_reg;
                        offset     = step_y_reg;
                        below      = 1'b1;
                        phase_next = csg_pkg::PH_END;
                    end
                endcase

                // Drop to idle once no span remains
                keep_going = (phase_next == csg_pkg::PH_BELOW_X) ||
                             (phase_next == csg_pkg::PH_ABOVE_Y) ||
                             (phase_next == csg_pkg::PH_BELOW_Y) ||
                             (phase_next == csg_pkg::PH_CLOSE)   ||
                             ((phase_next == csg_pkg::PH_ABOVE_X) &&
                              (step_x_next <= step_y_next));
                if (!keep_going)
                begin
                    flags.last_span = 1'b1;
                    active_next     = 1'b0;
                    phase_next      = csg_pkg::PH_ABOVE_X;
                end
            end
        end
    end

    // Form the span ends and row, then truncate to the coordinate width
    always_comb
    begin
        col_w     = $signed({{(WB-CB){centre_col_reg[CB-1]}}, centre_col_reg});
        row_w     = $signed({{(WB-CB){centre_row_reg[CB-1]}}, centre_row_reg});
        half_w    = $signed({{(WB-SB){1'b0}}, half});
        off_w     = $signed({{(WB-SB){1'b0}}, offset});
        left_w    = col_w - half_w;
        right_w   = col_w + half_w;
        row_out_w = below ? (row_w + off_w) : (row_w - off_w);
        if (flags.span_valid)
        begin
            left  = left_w[COORD_BITS-1:0];
            right = right_w[COORD_BITS-1:0];
            row   = row_out_w[COORD_BITS-1:0];
        end
        else
        begin
            left  = '0;
            right = '0;
            row   = '0;
        end
    end

    // Hold the circle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_col_reg <= '0;
            centre_row_reg <= '0;
            step_x_reg     <= '0;
            step_y_reg     <= '0;
            decision_reg   <= '0;
            phase_reg      <= csg_pkg::PH_ABOVE_X;
            active_reg     <= 1'b0;
        end
        else
        begin
            centre_col_reg <= centre_col_next;
            centre_row_reg <= centre_row_next;
            step_x_reg     <= step_x_next;
            step_y_reg     <= step_y_next;
            decision_reg   <= decision_next;
            phase_reg      <= phase_next;
            active_reg     <= active_next;
        end
    end

endmodule

### sv/circle_span_generator.sv
// Top level of the circle span generator: input register, span logic,
// result register. Depends on csg_pkg, csg_cfg_regs and csg_step.
//
// Usage: each input transfer carries a command. A start command latches the
// centre and diameter and returns one result with no span (done_res set if
// the circle's bounding box misses the clip rectangle). Each next command
// returns one result: a span with span_valid set, last_span on the final
// one, or done_res set once the circle is finished or rejected.
// Every input transfer yields exactly one output transfer, in order.
// Latency: each result passes the input register, then the result register.
// Throughput: one item per cycle while out_stall is low, set by the single
// pass of the span logic between the two registers.
// Stall: while out_stall is high the result register holds; the input
// register still takes one more item, then in_stall rises until the
// result drains.
// Reset: the clip rectangle returns to the full 0..4095 square, no circle
// is active, and both registers are empty. The clip registers are written
// through cfg_valid/cfg_ready/cfg_index/cfg_data; write them only while the
// block holds no pending item.
module circle_span_generator
#(
    parameter int COORD_BITS = csg_pkg::COORD_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [csg_pkg::INDEX_BITS-1:0]         cfg_index,
    input  logic [csg_pkg::CLIP_BITS-1:0]          cfg_data,
    // Input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   command,
    input  logic signed [csg_pkg::CENTRE_BITS-1:0] centre_x,
    input  logic signed [csg_pkg::CENTRE_BITS-1:0] centre_y,
    input  logic [csg_pkg::DIAM_BITS-1:0]          diameter,
    // Output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   span_valid,
    output logic signed [COORD_BITS-1:0]           span_left,
    output logic signed [COORD_BITS-1:0]           span_right,
    output logic signed [COORD_BITS-1:0]           span_row,
    output logic                                   last_span,
    output logic                                   done_res
);

    csg_pkg::clip_t                clip;
    csg_pkg::item_t                item_reg;
    logic                          item_valid_reg, item_valid_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          in_take;
    logic                          advance;
    csg_pkg::flags_t               flags;
    csg_pkg::flags_t               flags_reg;
    logic signed [COORD_BITS-1:0]  left, right, row;
    logic signed [COORD_BITS-1:0]  left_reg, right_reg, row_reg;

    csg_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clip      (clip)
    );

    csg_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .clip  (clip),
        .flags (flags),
        .left  (left),
        .right (right),
        .row   (row)
    );

    // Advance the held item when the result register is free or draining
    assign advance  = item_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = item_valid_reg & ~advance;
    assign in_take  = in_valid & ~in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Track occupancy of both registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Load payloads on transfer
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.command  <= command;
            item_reg.centre_x <= centre_x;
            item_reg.centre_y <= centre_y;
            item_reg.diameter <= diameter;
        end
        if (advance)
        begin
            flags_reg <= flags;
            left_reg  <= left;
            right_reg <= right;
            row_reg   <= row;
        end
    end

    assign out_valid  = out_valid_reg;
    assign span_valid = flags_reg.span_valid;
    assign last_span  = flags_reg.last_span;
    assign done_res   = flags_reg.done_res;
    assign span_left  = left_reg;
    assign span_right = right_reg;
    assign span_row   = row_reg;

endmodule

### bench/testbench.sv
// Self-checking bench for circle_span_generator: directed rows, then random circles
// under several clip rectangles, checked against a span walker kept in step.
// Depends on csg_pkg and the circle_span_generator RTL.
module testbench;

    localparam int CW            = csg_pkg::COORD_BITS_DEF;
    localparam int LONG_HOLD     = 60;
    localparam int TIMEOUT_TICKS = 1000000;
    localparam int DIR_ROWS      = 25;

    typedef logic signed [csg_pkg::CENTRE_BITS-1:0] centre_t;
    typedef logic [csg_pkg::DIAM_BITS-1:0]          diam_t;

    typedef struct packed {
        logic                 span_valid;
        logic signed [CW-1:0] span_left;
        logic signed [CW-1:0] span_right;
        logic signed [CW-1:0] span_row;
        logic                 last_span;
        logic                 done_res;
    } span_res_t;

    // Directed row: typed rows carry a flag-only expectation with zero coordinates
    typedef struct {
        logic cmd;
        int   cx;
        int   cy;
        int   d;
        bit   typed;
        logic e_valid;
        logic e_last;
        logic e_done;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [csg_pkg::INDEX_BITS-1:0]         cfg_index = '0;
    logic [csg_pkg::CLIP_BITS-1:0]          cfg_data = '0;
    logic                                   in_valid = 1'b0;
    logic                                   in_stall;
    logic                                   command = csg_pkg::CMD_NEXT;
    logic signed [csg_pkg::CENTRE_BITS-1:0] centre_x = '0;
    logic signed [csg_pkg::CENTRE_BITS-1:0] centre_y = '0;
    logic [csg_pkg::DIAM_BITS-1:0]          diameter = '0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic                                   span_valid;
    logic signed [CW-1:0]                   span_left;
    logic signed [CW-1:0]                   span_right;
    logic signed [CW-1:0]                   span_row;
    logic                                   last_span;
    logic                                   done_res;

    // Walker state: clip rectangle and the circle in progress
    int win_left = 0;
    int win_right = 4095;
    int win_top = 0;
    int win_bottom = 4095;
    int ctr_col = 0;
    int ctr_row = 0;
    int walk_x = 0;
    int walk_y = 0;
    int walk_dec = 0;
    logic [csg_pkg::PHASE_BITS-1:0] walk_phase = csg_pkg::PH_ABOVE_X;
    bit circle_on = 1'b0;

    span_res_t span_q [$];
    int        fails = 0;

    // Sender and receiver pacing controls
    bit sender_quiet = 1'b0;
    bit sender_eager = 1'b0;
    bit hold_req = 1'b0;
    bit hold_served = 1'b0;
    int hold_cnt = 0;
    int stall_run = 0;
    bit stall_on = 1'b0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b1, 1'b0, 1'b0, 1'b1},
        '{csg_pkg::CMD_START,     0,     0,    0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b1, 1'b1, 1'b1, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b1, 1'b0, 1'b0, 1'b1},
        '{csg_pkg::CMD_START,  2047,  2047,    1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_START, -2048, -2048, 2047, 1'b1, 1'b0, 1'b0, 1'b1},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b1, 1'b0, 1'b0, 1'b1},
        '{csg_pkg::CMD_START,  2047,    -1,    2, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_START,     0,     0, 2047, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_START,    -5,     3,    5, 1'b1, 1'b0, 1'b0, 1'b1},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b1, 1'b0, 1'b0, 1'b1},
        '{csg_pkg::CMD_START,    10,    10, 2046, 1'b0, 1'b0, 1'b0, 1'b0},
        '{csg_pkg::CMD_NEXT,      0,     0,    0, 1'b0, 1'b0, 1'b0, 1'b0}
    };

    circle_span_generator #(.COORD_BITS(CW)) dut (.*);

    // Free-running clock
    always #5 clk = ~clk;

    // Advance the circle walker by one transfer and return the span it yields
    function automatic span_res_t walk_circle(input csg_pkg::item_t it);
        span_res_t res;
        int xc;
        int yc;
        int d;
        int r;
        int x;
        int y;
        int lft;
        int rgt;
        int row;
        res = '0;
        lft = 0;
        rgt = 0;
        row = 0;
        if (it.command == csg_pkg::CMD_START) begin
            xc = it.centre_x;
            yc = it.centre_y;
            d = it.diameter;
            r = d / 2;
            ctr_col = xc;
            ctr_row = yc;
            walk_x = 0;
            walk_y = r;
            walk_dec = int'(csg_pkg::DEC_INIT) - d;
            walk_phase = csg_pkg::PH_ABOVE_X;
            circle_on = 1'b1;
            // Reject when the bounding box misses the clip rectangle
            if (xc + r < win_left || xc - r > win_right ||
                yc + r < win_top || yc - r > win_bottom) begin
                circle_on = 1'b0;
                res.done_res = 1'b1;
            end
        end else if (!circle_on) begin
            res.done_res = 1'b1;
        end else begin
            x = walk_x;
            y = walk_y;
            res.span_valid = 1'b1;
            case (walk_phase)
                csg_pkg::PH_ABOVE_X: begin
                    if (x < y) begin
                        lft = ctr_col - y;
                        rgt = ctr_col + y;
                        row = ctr_row - x;
                        walk_phase = csg_pkg::PH_BELOW_X;
                    end else begin
                        lft = ctr_col - x;
                        rgt = ctr_col + x;
                        row = ctr_row - y;
                        walk_phase = csg_pkg::PH_CLOSE;
                    end
                end
                csg_pkg::PH_BELOW_X: begin
                    lft = ctr_col - y;
                    rgt = ctr_col + y;
                    row = ctr_row + x;
                    if (walk_dec < 0) begin
                        walk_dec = walk_dec + 4 * x + int'(csg_pkg::DEC_STEP_X);
                        walk_x = x + 1;
                        walk_phase = csg_pkg::PH_ABOVE_X;
                    end else begin
                        walk_phase = csg_pkg::PH_ABOVE_Y;
                    end
                end
                csg_pkg::PH_ABOVE_Y: begin
                    lft = ctr_col - x;
                    rgt = ctr_col + x;
                    row = ctr_row - y;
                    walk_phase = csg_pkg::PH_BELOW_Y;
                end
                csg_pkg::PH_BELOW_Y: begin
                    lft = ctr_col - x;
                    rgt = ctr_col + x;
                    row = ctr_row + y;
                    walk_dec = walk_dec + 4 * (x - y) + int'(csg_pkg::DEC_STEP_XY);
                    walk_y = y - 1;
                    walk_x = x + 1;
                    walk_phase = csg_pkg::PH_ABOVE_X;
                end
                default: begin
                    lft = ctr_col - x;
                    rgt = ctr_col + x;
                    row = ctr_row + y;
                    walk_phase = csg_pkg::PH_END;
                end
            endcase
            // Finish the circle once no further span is pending
            if (!(walk_phase inside {csg_pkg::PH_BELOW_X, csg_pkg::PH_ABOVE_Y,
                                     csg_pkg::PH_BELOW_Y, csg_pkg::PH_CLOSE} ||
                  (walk_phase == csg_pkg::PH_ABOVE_X && walk_x <= walk_y))) begin
                res.last_span = 1'b1;
                circle_on = 1'b0;
                walk_phase = csg_pkg::PH_ABOVE_X;
            end
        end
        res.span_left = lft[CW-1:0];
        res.span_right = rgt[CW-1:0];
        res.span_row = row[CW-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        if (sender_quiet || sender_eager)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Place a centre near the clip window most of the time
    function automatic centre_t pick_centre(input int lo, input int hi);
        int a;
        int b;
        if ($urandom_range(0, 99) < 35)
            return centre_t'($urandom);
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        a = (a - 40 < -2048) ? -2048 : a - 40;
        b = (b + 40 > 2047) ? 2047 : b + 40;
        if (a > b)
            return centre_t'($urandom);
        return centre_t'(a + int'($urandom_range(0, b - a)));
    endfunction

    function automatic csg_pkg::item_t raw_item(input logic cmd);
        csg_pkg::item_t it;
        it.command = cmd;
        it.centre_x = centre_t'($urandom);
        it.centre_y = centre_t'($urandom);
        it.diameter = diam_t'($urandom);
        return it;
    endfunction

    // Offer one item, hold it until the transfer, then queue its expected span
    task automatic send_item(input csg_pkg::item_t it, input bit typed,
                             input span_res_t typed_exp);
        int gap;
        span_res_t want;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= it.command;
        centre_x <= it.centre_x;
        centre_y <= it.centre_y;
        diameter <= it.diameter;
        do @(posedge clk); while (in_stall);
        want = walk_circle(it);
        span_q.push_back(typed ? typed_exp : want);
    endtask

    // Drain the block, then rewrite all four clip edges, starting at a random edge
    task automatic reconfigure(input int lft, input int rgt, input int top, input int bot);
        logic [csg_pkg::INDEX_BITS-1:0] reg_order [4];
        int vals [4];
        int first;
        int k;
        reg_order = '{csg_pkg::REG_CLIP_LEFT, csg_pkg::REG_CLIP_RIGHT,
                      csg_pkg::REG_CLIP_TOP, csg_pkg::REG_CLIP_BOTTOM};
        vals = '{lft, rgt, top, bot};
        in_valid <= 1'b0;
        wait (span_q.size() == 0);
        repeat (4) @(posedge clk);
        first = $urandom_range(0, 3);
        for (int n = 0; n < 4; n++) begin
            k = (first + n) % 4;
            cfg_valid <= 1'b1;
            cfg_index <= reg_order[k];
            cfg_data <= vals[k][csg_pkg::CLIP_BITS-1:0];
            do @(posedge clk); while (!cfg_ready);
            case (reg_order[k])
                csg_pkg::REG_CLIP_LEFT:   win_left = vals[k] & 'hFFF;
                csg_pkg::REG_CLIP_RIGHT:  win_right = vals[k] & 'hFFF;
                csg_pkg::REG_CLIP_TOP:    win_top = vals[k] & 'hFFF;
                csg_pkg::REG_CLIP_BOTTOM: win_bottom = vals[k] & 'hFFF;
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly whole circles with random content, some aborted, some noise
    task automatic run_circles(input int budget);
        int sent;
        int pick;
        int d;
        int limit;
        int cnt;
        csg_pkg::item_t it;
        sent = 0;
        while (sent < budget) begin
            sender_quiet = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                it = raw_item(1'($urandom_range(0, 1)));
                send_item(it, 1'b0, '0);
                sent++;
            end else begin
                if (pick < 75)
                    d = $urandom_range(0, 24);
                else if (pick < 93)
                    d = $urandom_range(25, 90);
                else
                    d = $urandom_range(91, 2047);
                it = raw_item(csg_pkg::CMD_START);
                it.diameter = diam_t'(d);
                it.centre_x = pick_centre(win_left, win_right);
                it.centre_y = pick_centre(win_top, win_bottom);
                send_item(it, 1'b0, '0);
                sent++;
                // Cut large circles and some others short; the next start restarts mid-circle
                if (d > 90 || $urandom_range(0, 99) < 12)
                    limit = $urandom_range(0, 40);
                else
                    limit = 100000;
                cnt = 0;
                while (circle_on && cnt < limit) begin
                    send_item(raw_item(csg_pkg::CMD_NEXT), 1'b0, '0);
                    cnt++;
                    sent++;
                end
                if (!circle_on && $urandom_range(0, 2) == 0) begin
                    send_item(raw_item(csg_pkg::CMD_NEXT), 1'b0, '0);
                    sent++;
                end
            end
        end
        sender_quiet = 1'b0;
    endtask

    // Receiver: random stall runs, plus one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_req && !hold_served) begin
            hold_served = 1'b1;
            hold_cnt = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            out_stall <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            out_stall <= stall_on;
        end else begin
            stall_on = ($urandom_range(0, 99) < 35);
            if (!stall_on)
                stall_run = $urandom_range(0, 30);
            else if ($urandom_range(0, 9) == 0)
                stall_run = $urandom_range(15, 50);
            else
                stall_run = $urandom_range(0, 2);
            out_stall <= stall_on;
        end
    end

    // Compare each output transfer with the oldest expectation
    always @(posedge clk) begin
        span_res_t got;
        span_res_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{span_valid, span_left, span_right, span_row, last_span, done_res};
            if (span_q.size() == 0) begin
                fails++;
                $display("%0t: expected no result, got valid %0b left %0d right %0d row %0d",
                         $time, got.span_valid, got.span_left, got.span_right, got.span_row);
            end else begin
                want = span_q.pop_front();
                if (got !== want) begin
                    fails++;
                    if (got.span_valid !== want.span_valid)
                        $display("%0t: span_valid expected %0b, got %0b",
                                 $time, want.span_valid, got.span_valid);
                    if (got.span_left !== want.span_left)
                        $display("%0t: span_left expected %0d, got %0d",
                                 $time, want.span_left, got.span_left);
                    if (got.span_right !== want.span_right)
                        $display("%0t: span_right expected %0d, got %0d",
                                 $time, want.span_right, got.span_right);
                    if (got.span_row !== want.span_row)
                        $display("%0t: span_row expected %0d, got %0d",
                                 $time, want.span_row, got.span_row);
                    if (got.last_span !== want.last_span)
                        $display("%0t: last_span expected %0b, got %0b",
                                 $time, want.last_span, got.last_span);
                    if (got.done_res !== want.done_res)
                        $display("%0t: done_res expected %0b, got %0b",
                                 $time, want.done_res, got.done_res);
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        csg_pkg::item_t it;
        span_res_t typed_exp;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (dir_tab[i]) begin
            it.command = dir_tab[i].cmd;
            it.centre_x = dir_tab[i].cx[csg_pkg::CENTRE_BITS-1:0];
            it.centre_y = dir_tab[i].cy[csg_pkg::CENTRE_BITS-1:0];
            it.diameter = dir_tab[i].d[csg_pkg::DIAM_BITS-1:0];
            typed_exp = '0;
            typed_exp.span_valid = dir_tab[i].e_valid;
            typed_exp.last_span = dir_tab[i].e_last;
            typed_exp.done_res = dir_tab[i].e_done;
            send_item(it, dir_tab[i].typed, typed_exp);
        end
        run_circles(140);

        // Narrow window, with a full drain halfway
        reconfigure(300, 900, 200, 700);
        run_circles(70);
        in_valid <= 1'b0;
        wait (span_q.size() == 0);
        @(posedge clk);
        run_circles(70);

        // Long receiver hold-off while the sender keeps offering
        reconfigure(0, 2047, 0, 2047);
        sender_eager = 1'b1;
        hold_req = 1'b1;
        run_circles(50);
        sender_eager = 1'b0;
        run_circles(90);

        // Inverted and extreme windows
        reconfigure(3000, 100, 2500, 50);
        run_circles(90);
        reconfigure(4095, 0, 4095, 0);
        run_circles(25);
        reconfigure(0, 0, 0, 0);
        run_circles(65);

        repeat (2) begin
            reconfigure($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095));
            run_circles(120);
        end
        reconfigure(0, 4095, 0, 4095);
        run_circles(160);

        // Drain and settle
        in_valid <= 1'b0;
        wait (span_q.size() == 0);
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_TICKS * 10);
        $display("simulation failed");
        $finish;
    end

endmodule
